### sv/hsv_color_interpolator_assert.svh
// ----------------------------------------------------------------------------
// hsv color interpolator assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef HSV_COLOR_INTERPOLATOR_ASSERT_SVH
`define HSV_COLOR_INTERPOLATOR_ASSERT_SVH

// plain property
`define HSVI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition implies a property in the next cycle
`define HSVI_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

### sv/hsvi_pkg.sv
// ----------------------------------------------------------------------------
// hsvi_pkg
// shared constants and types of the hsv color interpolator
// ----------------------------------------------------------------------------
package hsvi_pkg;

    localparam int BLEND_FRAC_BITS = 8;
    localparam int BLEND_W         = BLEND_FRAC_BITS + 1;
    localparam logic [BLEND_W-1:0] BLEND_FULL = BLEND_W'(1) << BLEND_FRAC_BITS;
    localparam logic [BLEND_W-1:0] BLEND_HALF = BLEND_FULL >> 1;

    localparam int HUE_FULL = 23040;
    localparam int HUE_HALF = 11520;
    localparam int HUE_SEXT = 3840;
    localparam int HUE_W    = 15;
    localparam int FRAC_W   = 17;

    localparam int DIV_Q_W    = 18;
    localparam int DIV_STEPS  = 6;
    localparam int DIV_STAGES = 3;
    localparam int NUM_STAGES = 10;

    typedef struct packed {
        logic [7:0]         start_red;
        logic [7:0]         start_green;
        logic [7:0]         start_blue;
        logic [7:0]         end_red;
        logic [7:0]         end_green;
        logic [7:0]         end_blue;
        logic [BLEND_W-1:0] blend;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_out_item;

    // long division state: partial remainder, numerator bits then quotient bits
    typedef struct packed {
        logic [7:0]         rem;
        logic [DIV_Q_W-1:0] nq;
        logic [7:0]         den;
    } t_div;

    typedef enum logic [2:0] {
        SX_RED_YEL = 3'd0,
        SX_YEL_GRN = 3'd1,
        SX_GRN_CYN = 3'd2,
        SX_CYN_BLU = 3'd3,
        SX_BLU_MAG = 3'd4,
        SX_MAG_RED = 3'd5
    } t_sextant;

endpackage

### sv/hsvi_if.sv
// ----------------------------------------------------------------------------
// hsvi channel interfaces
// valid/ready channels for color pairs in and blended colors out
// ----------------------------------------------------------------------------
interface hsvi_in_if;
    import hsvi_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hsvi_out_if;
    import hsvi_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/hsv_color_interpolator.sv
// ----------------------------------------------------------------------------
// hsv_color_interpolator
// Blends two RGB colors in HSV space along the shorter hue arc. One color
// pair is taken per clock unless the output side stalls the pipeline.
// The hue and saturation dividers, three stages of six quotient bits each,
// sit between the HSV conversion front end and the blend, sextant, product,
// scaling and rounding stages. Every stage holds its item on a stall and
// empty stages fill up, so the input stays ready while any stage is free.
// ----------------------------------------------------------------------------
module hsv_color_interpolator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hsvi_in_if.sink           i_in,
    hsvi_out_if.source        o_out
);
    import hsvi_pkg::*;

    localparam int HACC_W  = 18 + BLEND_FRAC_BITS + 2;
    localparam int SACC_W  = FRAC_W + BLEND_W + 1;
    localparam int PART_W  = 45;
    localparam int Z_W     = 54;
    localparam int W_LO    = 40;
    localparam int RECIP_15 = 17477;

    typedef struct packed {
        logic [HUE_W-1:0]  base;
        logic              neg;
        logic              red_max;
        logic              gray;
        logic [FRAC_W-1:0] val;
    } t_side;

    typedef struct packed {
        t_side side;
        t_div  hue_div;
        t_div  sat_div;
    } t_prep;

    function automatic t_prep prep_color(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        t_prep             p;
        logic [7:0]        mx;
        logic [7:0]        mn;
        logic [7:0]        d;
        logic signed [8:0] df;
        logic [7:0]        mag;
        logic [23:0]       hnum;
        logic [23:0]       snum;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        p.side.red_max = 1'b0;
        if (mx == r) begin
            df             = $signed({1'b0, g}) - $signed({1'b0, b});
            p.side.base    = '0;
            p.side.red_max = 1'b1;
        end else if (mx == g) begin
            df          = $signed({1'b0, b}) - $signed({1'b0, r});
            p.side.base = HUE_W'(2 * HUE_SEXT);
        end else begin
            df          = $signed({1'b0, r}) - $signed({1'b0, g});
            p.side.base = HUE_W'(4 * HUE_SEXT);
        end
        p.side.neg  = df[8];
        mag         = df[8] ? 8'(-df) : df[7:0];
        hnum        = 24'(mag) * 24'(HUE_SEXT);
        snum        = {d, 16'h0};
        p.hue_div.rem = {2'b0, hnum[23:18]};
        p.hue_div.nq  = hnum[17:0];
        p.hue_div.den = d;
        p.sat_div.rem = {2'b0, snum[23:18]};
        p.sat_div.nq  = snum[17:0];
        p.sat_div.den = mx;
        p.side.gray = (d == 8'h0);
        p.side.val  = {1'b0, mx, mx} + FRAC_W'(mx == 8'hFF);
        return p;
    endfunction

    function automatic logic [HUE_W-1:0] final_hue(input t_side sd,
                                                   input logic [DIV_Q_W-1:0] q);
        logic [HUE_W-1:0] qh;
        logic [HUE_W-1:0] h;
        qh = q[HUE_W-1:0];
        if (sd.gray) begin
            h = '0;
        end else if (sd.neg) begin
            if (sd.red_max) begin
                h = (qh == '0) ? '0 : HUE_W'(HUE_FULL) - qh;
            end else begin
                h = sd.base - qh;
            end
        end else begin
            h = sd.base + qh;
        end
        return h;
    endfunction

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;
    logic                  w_in_acc;
    logic                  w_out_acc;

    // stage 0 to 3: conversion front end and dividers
    t_side            r_side_a [DIV_STAGES+1];
    t_side            r_side_b [DIV_STAGES+1];
    logic [BLEND_W-1:0] r_t    [DIV_STAGES+1];
    t_div             r_div0   [4];
    t_div             w_div    [4][DIV_STAGES+1];
    t_prep            n_pa;
    t_prep            n_pb;
    logic [BLEND_W-1:0] n_t;

    // stage 4
    logic [HUE_W-1:0]   r_s4_ha, n_s4_ha;
    logic signed [16:0] r_s4_dh, n_s4_dh;
    logic [FRAC_W-1:0]  r_s4_sa, n_s4_sa, r_s4_sb, n_s4_sb;
    logic [FRAC_W-1:0]  r_s4_va, r_s4_vb;
    logic [BLEND_W-1:0] r_s4_t;

    // stage 5
    logic [16:0]       r_s5_hq, n_s5_hq;
    logic [FRAC_W-1:0] r_s5_s, n_s5_s, r_s5_v, n_s5_v;

    // stage 6
    t_sextant          r_s6_sx, n_s6_sx;
    logic [11:0]       r_s6_k, n_s6_k;
    logic [33:0]       r_s6_c, n_s6_c;
    logic [FRAC_W-1:0] r_s6_v;

    // stage 7 to 9
    logic [PART_W-1:0] r_s7_part [3];
    logic [PART_W-1:0] n_s7_part [3];
    logic [PART_W-1:0] r_s7_m, n_s7_m;
    logic [11:0]       r_s8_w [3];
    logic [11:0]       n_s8_w [3];
    logic [7:0]        r_s9_ch [3];
    logic [7:0]        n_s9_ch [3];

    // stall handling
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_out.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready  = w_en[0];
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_acc   = o_out.valid && o_out.ready;
    assign o_out.valid = r_vld[NUM_STAGES-1];
    assign o_out.data  = '{out_red: r_s9_ch[0], out_green: r_s9_ch[1], out_blue: r_s9_ch[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0
    always_comb begin
        n_pa = prep_color(i_in.data.start_red, i_in.data.start_green, i_in.data.start_blue);
        n_pb = prep_color(i_in.data.end_red, i_in.data.end_green, i_in.data.end_blue);
        n_t  = (i_in.data.blend > BLEND_FULL) ? BLEND_FULL : i_in.data.blend;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side_a[0] <= n_pa.side;
            r_side_b[0] <= n_pb.side;
            r_t[0]      <= n_t;
            r_div0[0]   <= n_pa.hue_div;
            r_div0[1]   <= n_pa.sat_div;
            r_div0[2]   <= n_pb.hue_div;
            r_div0[3]   <= n_pb.sat_div;
        end
        for (int s = 1; s <= DIV_STAGES; s++) begin
            if (w_en[s]) begin
                r_side_a[s] <= r_side_a[s-1];
                r_side_b[s] <= r_side_b[s-1];
                r_t[s]      <= r_t[s-1];
            end
        end
    end

    // stage 1 to 3: hue and saturation division
    for (genvar j = 0; j < 4; j++) begin : g_div
        assign w_div[j][0] = r_div0[j];
        for (genvar s = 0; s < DIV_STAGES; s++) begin : g_step
            hsvi_div_step u_step (
                .i_clk (i_clk),
                .i_en  (w_en[s+1]),
                .i_div (w_div[j][s]),
                .o_div (w_div[j][s+1])
            );
        end
    end

    // stage 4: final hsv and hue difference
    always_comb begin
        logic [HUE_W-1:0]   hb;
        logic signed [16:0] diff;
        n_s4_ha = final_hue(r_side_a[DIV_STAGES], w_div[0][DIV_STAGES].nq);
        hb      = final_hue(r_side_b[DIV_STAGES], w_div[2][DIV_STAGES].nq);
        n_s4_sa = r_side_a[DIV_STAGES].gray ? '0 : w_div[1][DIV_STAGES].nq[FRAC_W-1:0];
        n_s4_sb = r_side_b[DIV_STAGES].gray ? '0 : w_div[3][DIV_STAGES].nq[FRAC_W-1:0];
        diff    = $signed({2'b0, hb}) - $signed({2'b0, n_s4_ha});
        if (diff < 0) begin
            diff = diff + $signed(17'(HUE_FULL));
        end
        if (diff > HUE_HALF) begin
            diff = diff - $signed(17'(HUE_FULL));
        end
        n_s4_dh = diff;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_ha <= n_s4_ha;
            r_s4_dh <= n_s4_dh;
            r_s4_sa <= n_s4_sa;
            r_s4_sb <= n_s4_sb;
            r_s4_va <= r_side_a[DIV_STAGES].val;
            r_s4_vb <= r_side_b[DIV_STAGES].val;
            r_s4_t  <= r_t[DIV_STAGES];
        end
    end

    // stage 5: blend
    always_comb begin
        logic signed [BLEND_W+17:0] hprod;
        logic signed [HACC_W-1:0]   hprod_x;
        logic signed [HACC_W-1:0]   hbase;
        logic signed [HACC_W-1:0]   hacc;
        logic [SACC_W-1:0]          wa;
        logic [SACC_W-1:0]          wb;
        logic [SACC_W-1:0]          sacc;
        logic [SACC_W-1:0]          vacc;
        hprod   = $signed({1'b0, r_s4_t}) * r_s4_dh;
        hprod_x = HACC_W'(hprod);
        hbase   = $signed((HACC_W'(r_s4_ha) + HACC_W'(HUE_FULL)) << BLEND_FRAC_BITS);
        hacc    = hbase + hprod_x + $signed(HACC_W'(BLEND_HALF));
        n_s5_hq = hacc[BLEND_FRAC_BITS +: 17];
        wa      = SACC_W'(BLEND_FULL - r_s4_t);
        wb      = SACC_W'(r_s4_t);
        sacc    = SACC_W'(r_s4_sa) * wa + SACC_W'(r_s4_sb) * wb + SACC_W'(BLEND_HALF);
        vacc    = SACC_W'(r_s4_va) * wa + SACC_W'(r_s4_vb) * wb + SACC_W'(BLEND_HALF);
        n_s5_s  = sacc[BLEND_FRAC_BITS +: FRAC_W];
        n_s5_v  = vacc[BLEND_FRAC_BITS +: FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_hq <= n_s5_hq;
            r_s5_s  <= n_s5_s;
            r_s5_v  <= n_s5_v;
        end
    end

    // stage 6: hue wrap, sextant, chroma
    always_comb begin
        logic [16:0]      hm;
        logic [HUE_W-1:0] h;
        logic [HUE_W-1:0] hr;
        logic [2:0]       sx_idx;
        hm = r_s5_hq;
        if (hm >= 17'(HUE_FULL)) hm = hm - 17'(HUE_FULL);
        if (hm >= 17'(HUE_FULL)) hm = hm - 17'(HUE_FULL);
        h      = hm[HUE_W-1:0];
        sx_idx = '0;
        for (int i = 1; i < 6; i++) begin
            if (h >= HUE_W'(i * HUE_SEXT)) sx_idx = 3'(i);
        end
        hr      = h - HUE_W'(32'(sx_idx) * HUE_SEXT);
        n_s6_k  = sx_idx[0] ? 12'(HUE_W'(HUE_SEXT) - hr) : hr[11:0];
        n_s6_sx = t_sextant'(sx_idx);
        n_s6_c  = 34'(r_s5_v) * 34'(r_s5_s);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s6_sx <= n_s6_sx;
            r_s6_k  <= n_s6_k;
            r_s6_c  <= n_s6_c;
            r_s6_v  <= r_s5_v;
        end
    end

    // stage 7: scaled channel parts
    always_comb begin
        logic [PART_W-1:0] cs;
        logic [PART_W-1:0] xs;
        cs     = PART_W'(r_s6_c) * PART_W'(HUE_SEXT);
        xs     = PART_W'(r_s6_c) * PART_W'(r_s6_k);
        n_s7_m = (PART_W'({r_s6_v, 16'h0}) - PART_W'(r_s6_c)) * PART_W'(HUE_SEXT);
        case (r_s6_sx)
            SX_RED_YEL: begin
                n_s7_part[0] = cs; n_s7_part[1] = xs; n_s7_part[2] = '0;
            end
            SX_YEL_GRN: begin
                n_s7_part[0] = xs; n_s7_part[1] = cs; n_s7_part[2] = '0;
            end
            SX_GRN_CYN: begin
                n_s7_part[0] = '0; n_s7_part[1] = cs; n_s7_part[2] = xs;
            end
            SX_CYN_BLU: begin
                n_s7_part[0] = '0; n_s7_part[1] = xs; n_s7_part[2] = cs;
            end
            SX_BLU_MAG: begin
                n_s7_part[0] = xs; n_s7_part[1] = '0; n_s7_part[2] = cs;
            end
            default: begin
                n_s7_part[0] = cs; n_s7_part[1] = '0; n_s7_part[2] = xs;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s7_part <= n_s7_part;
            r_s7_m    <= n_s7_m;
        end
    end

    // stage 8: times 255 with rounding, then drop the 2^40 part of the scale
    always_comb begin
        logic [Z_W-1:0] y;
        logic [Z_W-1:0] z;
        for (int ch = 0; ch < 3; ch++) begin
            y         = Z_W'(r_s7_part[ch]) + Z_W'(r_s7_m);
            z         = (y << 8) - y + (Z_W'(HUE_SEXT / 2) << 32);
            n_s8_w[ch] = z[W_LO +: 12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_s8_w <= n_s8_w;
        end
    end

    // stage 9: divide by 15 via reciprocal, exact for 12-bit operands, clamp
    always_comb begin
        logic [26:0] p;
        logic [8:0]  q;
        for (int ch = 0; ch < 3; ch++) begin
            p           = 27'(r_s8_w[ch]) * 27'(RECIP_15);
            q           = p[26:18];
            n_s9_ch[ch] = (q > 9'd255) ? 8'hFF : q[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r_s9_ch <= n_s9_ch;
        end
    end

    `include "hsv_color_interpolator_assert.svh"

    `HSVI_ASSERT(a_ready_when_drained, !r_vld[NUM_STAGES-1] |-> i_in.ready, "input stalled with empty output stage")
    `HSVI_ASSERT_NEXT(a_occ_up, w_in_acc && !w_out_acc, $countones(r_vld) == $past($countones(r_vld)) + 1, "accepted transaction lost")
    `HSVI_ASSERT_NEXT(a_occ_down, !w_in_acc && w_out_acc, $countones(r_vld) + 1 == $past($countones(r_vld)), "delivered transaction not retired")
    `HSVI_ASSERT_NEXT(a_occ_hold, w_in_acc == w_out_acc, $countones(r_vld) == $past($countones(r_vld)), "pipeline occupancy changed")

endmodule

### sv/hsvi_div_step.sv
// ----------------------------------------------------------------------------
// hsvi_div_step
// one registered stage of restoring division, six quotient bits per stage
// ----------------------------------------------------------------------------
module hsvi_div_step (
    input  logic          i_clk,
    input  logic          i_en,
    input  hsvi_pkg::t_div i_div,
    output hsvi_pkg::t_div o_div
);
    import hsvi_pkg::*;

    t_div n_div;
    t_div r_div;

    always_comb begin
        logic [8:0] trial;
        logic       qbit;
        n_div = i_div;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {n_div.rem, n_div.nq[DIV_Q_W-1]};
            if (trial >= {1'b0, n_div.den}) begin
                n_div.rem = 8'(trial - {1'b0, n_div.den});
                qbit      = 1'b1;
            end else begin
                n_div.rem = trial[7:0];
                qbit      = 1'b0;
            end
            n_div.nq = {n_div.nq[DIV_Q_W-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed color pairs with blend factors through the
// hsv color interpolator and checks every blended color against an
// in-bench fixed point HSV predictor, with bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import hsvi_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hsvi_in_if  in_ch ();
    hsvi_out_if out_ch ();

    hsv_color_interpolator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    t_in_item  pending_pairs[$];
    t_out_item expected_colors[$];
    int        errors = 0;
    int        sent = 0;
    int        checked = 0;
    bit        hold_sender = 1'b0;
    int        gap_left = 0;
    int        burst_left = 0;
    int        stall_phase = 0;

    function automatic void color_to_hsv(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b,
                                         output longint h, output longint s,
                                         output longint v);
        longint mx, mn, d;
        mx = r; mn = r; h = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d != 0) begin
            if (mx == r) begin
                h = (HUE_SEXT * (longint'(g) - longint'(b))) / d;
                if (h < 0) h += HUE_FULL;
            end else if (mx == g) begin
                h = 2 * HUE_SEXT + (HUE_SEXT * (longint'(b) - longint'(r))) / d;
            end else begin
                h = 4 * HUE_SEXT + (HUE_SEXT * (longint'(r) - longint'(g))) / d;
            end
        end
        s = (mx == 0) ? 0 : (d * 65536) / mx;
        v = (mx * 65536) / 255;
    endfunction

    function automatic logic [7:0] scale_channel(logic [63:0] part, logic [63:0] m);
        logic [63:0] den, q;
        den = 64'(HUE_SEXT) << 32;
        q = ((part + m) * 255 + den / 2) / den;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic t_out_item blend_color(t_in_item it);
        longint ha, sa, va, hb, sb, vb, t, dh, full, half;
        logic [63:0] h, s, v, c, q, k, cs, xs, ms, rs, gs, bs;
        t_out_item res;
        full = longint'(1) << BLEND_FRAC_BITS;
        half = full >> 1;
        color_to_hsv(it.start_red, it.start_green, it.start_blue, ha, sa, va);
        color_to_hsv(it.end_red, it.end_green, it.end_blue, hb, sb, vb);
        t = it.blend;
        if (t > full) t = full;
        dh = (hb - ha + HUE_FULL) % HUE_FULL;
        if (dh > HUE_HALF) dh -= HUE_FULL;
        h = ((ha + HUE_FULL) * full + t * dh + half) >>> BLEND_FRAC_BITS;
        h = h % HUE_FULL;
        s = (sa * (full - t) + sb * t + half) >> BLEND_FRAC_BITS;
        v = (va * (full - t) + vb * t + half) >> BLEND_FRAC_BITS;
        c = v * s;
        q = h % (2 * HUE_SEXT);
        k = (q >= HUE_SEXT) ? (2 * HUE_SEXT - q) : q;
        cs = c * HUE_SEXT;
        xs = c * k;
        ms = ((v << 16) - c) * HUE_SEXT;
        case (t_sextant'(h / HUE_SEXT))
            SX_RED_YEL: begin rs = cs; gs = xs; bs = 0;  end
            SX_YEL_GRN: begin rs = xs; gs = cs; bs = 0;  end
            SX_GRN_CYN: begin rs = 0;  gs = cs; bs = xs; end
            SX_CYN_BLU: begin rs = 0;  gs = xs; bs = cs; end
            SX_BLU_MAG: begin rs = xs; gs = 0;  bs = cs; end
            default: begin rs = cs; gs = 0;  bs = xs; end
        endcase
        res.out_red   = scale_channel(rs, ms);
        res.out_green = scale_channel(gs, ms);
        res.out_blue  = scale_channel(bs, ms);
        return res;
    endfunction

    function automatic t_in_item make_pair(logic [7:0] r0, logic [7:0] g0, logic [7:0] b0,
                                           logic [7:0] r1, logic [7:0] g1, logic [7:0] b1,
                                           logic [BLEND_W-1:0] t);
        t_in_item it;
        it = '{r0, g0, b0, r1, g1, b1, t};
        return it;
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [BLEND_W-1:0] rand_blend();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return BLEND_FULL;
            2: return BLEND_W'($urandom_range(BLEND_FULL + 1, (1 << BLEND_W) - 1));
            3: return BLEND_HALF;
            default: return BLEND_W'($urandom_range(0, BLEND_FULL));
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                expected_colors.push_back(blend_color(in_ch.data));
                sent++;
            end
            if (pending_pairs.size() == 0 || hold_sender) begin
                in_ch.valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_pairs.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver stall pattern and monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected color %h, nothing expected", $time, out_ch.data);
                    errors++;
                end else begin
                    if (out_ch.data.out_red != expected_colors[0].out_red)
                        $display("%0t: red expected %0d actual %0d", $time,
                                 expected_colors[0].out_red, out_ch.data.out_red);
                    if (out_ch.data.out_green != expected_colors[0].out_green)
                        $display("%0t: green expected %0d actual %0d", $time,
                                 expected_colors[0].out_green, out_ch.data.out_green);
                    if (out_ch.data.out_blue != expected_colors[0].out_blue)
                        $display("%0t: blue expected %0d actual %0d", $time,
                                 expected_colors[0].out_blue, out_ch.data.out_blue);
                    if (out_ch.data != expected_colors[0]) errors++;
                    void'(expected_colors.pop_front());
                    checked++;
                end
            end
            stall_phase = (stall_phase + 1) % 200;
            if (stall_phase < 40) out_ch.ready <= 1'b1;
            else if (stall_phase < 120) out_ch.ready <= ($urandom_range(0, 3) != 0);
            else out_ch.ready <= ($urandom_range(0, 2) == 0);
        end
    end

    initial begin
        #2000000;
        $display("timeout after %0d transactions checked", checked);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [7:0] c0, c1;
        pending_pairs.push_back(make_pair(0, 0, 0, 255, 255, 255, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 255, 255, 255, BLEND_FULL));
        pending_pairs.push_back(make_pair(128, 128, 128, 40, 40, 40, BLEND_HALF));
        pending_pairs.push_back(make_pair(255, 255, 0, 0, 255, 255, 100));
        pending_pairs.push_back(make_pair(0, 255, 255, 255, 0, 255, 77));
        pending_pairs.push_back(make_pair(255, 0, 0, 0, 255, 255, BLEND_HALF));
        pending_pairs.push_back(make_pair(0, 255, 0, 255, 0, 255, 200));
        pending_pairs.push_back(make_pair(255, 0, 0, 0, 0, 255, 130));
        pending_pairs.push_back(make_pair(255, 0, 10, 10, 0, 255, BLEND_HALF));
        pending_pairs.push_back(make_pair(255, 0, 0, 0, 255, 0, 9'h1ff));
        pending_pairs.push_back(make_pair(10, 200, 30, 90, 20, 250, 9'h101));
        pending_pairs.push_back(make_pair(255, 255, 255, 255, 0, 0, 1));
        pending_pairs.push_back(make_pair(0, 0, 1, 1, 0, 0, 255));
        pending_pairs.push_back(make_pair(255, 128, 0, 0, 128, 255, 64));
        pending_pairs.push_back(make_pair(8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 9'h0aa));
        for (int i = 0; i < 1640; i++) begin
            c0 = rand_chan();
            c1 = rand_chan();
            if ($urandom_range(0, 9) == 0)
                pending_pairs.push_back(make_pair(c0, c0, c0, c1, c1, rand_chan(), rand_blend()));
            else
                pending_pairs.push_back(make_pair(rand_chan(), rand_chan(), rand_chan(),
                                                  rand_chan(), rand_chan(), rand_chan(),
                                                  rand_blend()));
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (sent >= 600);
        hold_sender = 1'b1;
        wait (expected_colors.size() == 0 && !in_ch.valid);
        @(posedge i_clk);
        hold_sender = 1'b0;
        wait (pending_pairs.size() == 0 && !in_ch.valid);
        wait (expected_colors.size() == 0);
        repeat (30) @(posedge i_clk);
        $display("checked %0d blended colors from %0d color pairs,", checked, sent);
        $display("including gray, tie, opposite hue and saturated blend cases");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
